@@ design/gwv_pkg.sv @@
// ----------------------------------------------------------------------------
// gwv_pkg: shared types and constants for the geodesic window validity check
// Q16.16 widths, saturation helpers and the square root pipeline state.
// ----------------------------------------------------------------------------
`default_nettype none

package gwv_pkg;

  localparam int VW        = 32;   // value width, signed Q16.16
  localparam int SW        = 35;   // width for exact sums before saturation
  localparam int FRAC_BITS = 16;
  localparam int PROP_W    = 17;   // Q1.16 proportion, 65536 means one
  localparam int DIST_W    = 31;   // unsigned distances
  localparam int PROD_W    = PROP_W + DIST_W;
  localparam int RAD_W     = 2 * VW;
  localparam int SQ_STAGES = 8;    // root pipeline stages
  localparam int SQ_STEPS  = VW / SQ_STAGES;  // root bits per stage
  localparam int LIMIT_RST = 10000 << FRAC_BITS;

  typedef struct packed {
    logic [VW+1:0]    rem;   // partial remainder
    logic [VW-1:0]    q;     // partial root
    logic [RAD_W-1:0] rad;   // radicand bits not yet consumed, top first
  } sq_state_t;

  typedef struct packed {
    logic [1:0]              flags;
    logic [DIST_W-1:0]       root;
    logic [DIST_W-1:0]       dl;
    logic [DIST_W-1:0]       dr;
    logic [DIST_W-1:0]       dop;
    logic signed [VW-1:0]    pos_l;
    logic signed [VW-1:0]    pos_r;
    logic signed [VW-1:0]    rest_l;
    logic signed [VW-1:0]    xv;
    logic signed [VW-1:0]    yv;
  } side_t;

  function automatic logic signed [VW-1:0] sat_v(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] mx;
    logic signed [SW-1:0] mn;
    mx = SW'(signed'({1'b0, {(VW-1){1'b1}}}));
    mn = -mx - SW'(signed'(2'sb01));
    if (v > mx) return {1'b0, {(VW-1){1'b1}}};
    else if (v < mn) return {1'b1, {(VW-1){1'b0}}};
    else return v[VW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] s_ext(input logic signed [VW-1:0] v);
    return {{(SW-VW){v[VW-1]}}, v};
  endfunction

  function automatic logic signed [SW-1:0] u_ext(input logic [DIST_W-1:0] v);
    return {{(SW-DIST_W){1'b0}}, v};
  endfunction

  function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

endpackage

`default_nettype wire

@@ design/geodesic_window_validity_check_top.sv @@
// ----------------------------------------------------------------------------
// geodesic_window_validity_check_top: geodesic window pruning test
// Keeps or prunes one unfolded window per request using three distance tests.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle unless stalled; the two pipelined
//   square roots (8 stages each) run side by side and set the depth, not the rate.
// Stalls: each stage holds while the one after it is full and stalled, so
//   bubbles collapse and input is taken while a result waits.
// Reset: rst (sync) empties the pipeline and reloads known_dist_limit.
`default_nettype none

module geodesic_window_validity_check_top (
  input  wire logic         clk,
  input  wire logic         rst,
  // request: {oy, ox, opp_vert_dist, right_vert_dist, left_vert_dist,
  //   edge_len, dist_to_root, prop_right, prop_left, source_y, source_x}
  //   source_x lowest, 3 zero pad bits on top
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [319:0] s_tdata,
  input  wire logic [1:0]   s_tuser,   // window_flags
  // result: bit0 window_valid, rest zero
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [7:0]        m_tdata,
  // known_dist_limit write
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [30:0]  cfg_data
);

  localparam int NS = 7 + gwv_pkg::SQ_STAGES;  // total register stages
  localparam int SQ0 = 4;                       // first root stage

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  // pipeline control: a stage loads when it is empty or its successor moves
  assign en[NS-1] = ~v[NS-1] | m_tready;
  for (genvar i = 0; i < NS-1; i++) begin : g_en
    assign en[i] = ~v[i] | en[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= s_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = v[NS-1];

  // config register
  logic [gwv_pkg::DIST_W-1:0] limit;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= gwv_pkg::DIST_W'(gwv_pkg::LIMIT_RST);
    end else if (cfg_valid) begin
      limit <= cfg_data;
    end
  end

  // request unpack
  logic signed [31:0] in_sx, in_sy, in_ox, in_oy;
  logic [16:0] in_pl, in_pr;
  logic [30:0] in_root, in_len, in_dl, in_dr, in_dop;
  assign in_sx   = s_tdata[31:0];
  assign in_sy   = s_tdata[63:32];
  assign in_pl   = s_tdata[80:64];
  assign in_pr   = s_tdata[97:81];
  assign in_root = s_tdata[128:98];
  assign in_len  = s_tdata[159:129];
  assign in_dl   = s_tdata[190:160];
  assign in_dr   = s_tdata[221:191];
  assign in_dop  = s_tdata[252:222];
  assign in_ox   = s_tdata[284:253];
  assign in_oy   = s_tdata[316:285];

  // stage 0: edge position products
  logic [gwv_pkg::PROD_W-1:0] a_pl, a_pr;
  logic [1:0] a_flags;
  logic signed [31:0] a_sx, a_sy, a_ox, a_oy;
  logic [30:0] a_root, a_len, a_dl, a_dr, a_dop;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_pl    <= gwv_pkg::PROD_W'(in_pl) * gwv_pkg::PROD_W'(in_len);
      a_pr    <= gwv_pkg::PROD_W'(in_pr) * gwv_pkg::PROD_W'(in_len);
      a_flags <= s_tuser;
      a_sx    <= in_sx;
      a_sy    <= in_sy;
      a_ox    <= in_ox;
      a_oy    <= in_oy;
      a_root  <= in_root;
      a_len   <= in_len;
      a_dl    <= in_dl;
      a_dr    <= in_dr;
      a_dop   <= in_dop;
    end
  end

  // stage 1: positions, differences, opposite vertex
  logic [31:0] pl_fl, pr_fl;
  logic [gwv_pkg::PROD_W:0] pl_up;
  logic signed [31:0] pos_l_c, pos_r_c;
  assign pl_fl = a_pl[gwv_pkg::PROD_W-1:gwv_pkg::FRAC_BITS];
  assign pr_fl = a_pr[gwv_pkg::PROD_W-1:gwv_pkg::FRAC_BITS];
  assign pl_up = {1'b0, a_pl} + (gwv_pkg::PROD_W+1)'((1 << gwv_pkg::FRAC_BITS) - 1);
  assign pos_l_c = pl_fl[31] ? 32'sh7fffffff : $signed(pl_fl);
  assign pos_r_c = pr_fl[31] ? 32'sh7fffffff : $signed(pr_fl);

  gwv_pkg::side_t b_side;
  logic signed [31:0] b_dx_l, b_dx_r, b_sy;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_side.flags  <= a_flags;
      b_side.root   <= a_root;
      b_side.dl     <= a_dl;
      b_side.dr     <= a_dr;
      b_side.dop    <= a_dop;
      b_side.pos_l  <= pos_l_c;
      b_side.pos_r  <= pos_r_c;
      b_side.rest_l <= gwv_pkg::sat_v(gwv_pkg::u_ext(a_len) -
                       $signed({2'b00, pl_up[gwv_pkg::PROD_W:gwv_pkg::FRAC_BITS]}));
      b_side.xv     <= gwv_pkg::sat_v(gwv_pkg::u_ext(a_len) - gwv_pkg::s_ext(a_ox));
      b_side.yv     <= gwv_pkg::sat_v(-gwv_pkg::s_ext(a_oy));
      b_dx_l        <= gwv_pkg::sat_v(gwv_pkg::s_ext(a_sx) - gwv_pkg::s_ext(pos_l_c));
      b_dx_r        <= gwv_pkg::sat_v(gwv_pkg::s_ext(a_sx) - gwv_pkg::s_ext(pos_r_c));
      b_sy          <= a_sy;
    end
  end

  // stage 2: squares
  gwv_pkg::side_t c_side;
  logic [63:0] c_sq_l, c_sq_r, c_sq_y;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_side <= b_side;
      c_sq_l <= 64'(gwv_pkg::mag(b_dx_l)) * 64'(gwv_pkg::mag(b_dx_l));
      c_sq_r <= 64'(gwv_pkg::mag(b_dx_r)) * 64'(gwv_pkg::mag(b_dx_r));
      c_sq_y <= 64'(gwv_pkg::mag(b_sy)) * 64'(gwv_pkg::mag(b_sy));
    end
  end

  // stage 3: radicands
  gwv_pkg::side_t d_side;
  logic [63:0] d_rad_l, d_rad_r;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      d_side  <= c_side;
      d_rad_l <= c_sq_l + c_sq_y;
      d_rad_r <= c_sq_r + c_sq_y;
    end
  end

  // stages 4..11: two roots, side data travels alongside
  logic [31:0] root_l, root_r;
  gwv_sqrt u_sqrt_l (
    .clk      (clk),
    .en       (en[SQ0 +: gwv_pkg::SQ_STAGES]),
    .rad_in   (d_rad_l),
    .root_out (root_l)
  );
  gwv_sqrt u_sqrt_r (
    .clk      (clk),
    .en       (en[SQ0 +: gwv_pkg::SQ_STAGES]),
    .rad_in   (d_rad_r),
    .root_out (root_r)
  );

  gwv_pkg::side_t side_d [gwv_pkg::SQ_STAGES];
  always_ff @(posedge clk) begin
    for (int k = 0; k < gwv_pkg::SQ_STAGES; k++) begin
      if (en[SQ0+k]) side_d[k] <= (k == 0) ? d_side : side_d[(k == 0) ? 0 : k-1];
    end
  end

  // stage 12: end tests, opposite vertex terms
  gwv_pkg::side_t s;
  logic signed [31:0] len_l, len_r, side_len, side_pos;
  logic side_left, fail_l, fail_r;
  assign s = side_d[gwv_pkg::SQ_STAGES-1];
  assign len_l = root_l[31] ? 32'sh7fffffff : $signed(root_l);
  assign len_r = root_r[31] ? 32'sh7fffffff : $signed(root_r);
  assign side_left = s.flags[1];
  assign side_len = side_left ? len_l : len_r;
  assign side_pos = side_left ? s.pos_l : s.pos_r;
  // left end uses the right proportion, right end the left one
  assign fail_l = (s.dl < limit) &&
    (gwv_pkg::sat_v(gwv_pkg::u_ext(s.dl) + gwv_pkg::s_ext(s.pos_r)) <
     gwv_pkg::sat_v(gwv_pkg::u_ext(s.root) + gwv_pkg::s_ext(len_r)));
  assign fail_r = (s.dr < limit) &&
    (gwv_pkg::sat_v(gwv_pkg::u_ext(s.dr) + gwv_pkg::s_ext(s.rest_l)) <
     gwv_pkg::sat_v(gwv_pkg::u_ext(s.root) + gwv_pkg::s_ext(len_l)));

  logic e_pseudo, e_fail, e_opp_known;
  logic signed [31:0] e_d, e_ex, e_yv;
  always_ff @(posedge clk) begin
    if (en[SQ0 + gwv_pkg::SQ_STAGES]) begin
      e_pseudo    <= s.flags[0];
      e_fail      <= fail_l | fail_r;
      e_opp_known <= s.dop < limit;
      e_d  <= gwv_pkg::sat_v(gwv_pkg::u_ext(s.root) + gwv_pkg::s_ext(side_len) -
                             gwv_pkg::u_ext(s.dop));
      e_ex <= gwv_pkg::sat_v(gwv_pkg::s_ext(s.xv) - gwv_pkg::s_ext(side_pos));
      e_yv <= s.yv;
    end
  end

  // stage 13: opposite vertex squares
  logic f_pseudo, f_fail, f_opp_known, f_d_pos;
  logic [63:0] f_sq_x, f_sq_y, f_sq_d;
  always_ff @(posedge clk) begin
    if (en[SQ0 + gwv_pkg::SQ_STAGES + 1]) begin
      f_pseudo    <= e_pseudo;
      f_fail      <= e_fail;
      f_opp_known <= e_opp_known;
      f_d_pos     <= ~e_d[31] && (e_d != '0);
      f_sq_x <= 64'(gwv_pkg::mag(e_ex)) * 64'(gwv_pkg::mag(e_ex));
      f_sq_y <= 64'(gwv_pkg::mag(e_yv)) * 64'(gwv_pkg::mag(e_yv));
      f_sq_d <= 64'(gwv_pkg::mag(e_d)) * 64'(gwv_pkg::mag(e_d));
    end
  end

  // stage 14: decision, output register
  logic opp_prune, keep;
  assign opp_prune = f_opp_known && f_d_pos && ((f_sq_x + f_sq_y) < f_sq_d);
  assign keep = f_pseudo | ~(f_fail | opp_prune);

  logic keep_q;
  always_ff @(posedge clk) begin
    if (en[NS-1]) keep_q <= keep;
  end
  assign m_tdata = {7'b0, keep_q};

endmodule

`default_nettype wire

@@ design/gwv_sqrt.sv @@
// ----------------------------------------------------------------------------
// gwv_sqrt: pipelined floor square root
// Digit-by-digit restoring root, four result bits per stage, per-stage enable.
// ----------------------------------------------------------------------------
`default_nettype none

module gwv_sqrt (
  input  wire logic                        clk,
  input  wire logic [gwv_pkg::SQ_STAGES-1:0] en,
  input  wire logic [gwv_pkg::RAD_W-1:0]   rad_in,
  output logic      [gwv_pkg::VW-1:0]      root_out
);

  gwv_pkg::sq_state_t st [gwv_pkg::SQ_STAGES];
  gwv_pkg::sq_state_t st_in [gwv_pkg::SQ_STAGES];
  gwv_pkg::sq_state_t st_next [gwv_pkg::SQ_STAGES];

  function automatic gwv_pkg::sq_state_t sq_step(input gwv_pkg::sq_state_t s);
    gwv_pkg::sq_state_t o;
    logic [gwv_pkg::VW+2:0] r;
    logic [gwv_pkg::VW+2:0] t;
    r = {s.rem[gwv_pkg::VW:0], s.rad[gwv_pkg::RAD_W-1 -: 2]};
    t = {1'b0, s.q, 2'b01};
    o.rad = {s.rad[gwv_pkg::RAD_W-3:0], 2'b00};
    if (r >= t) begin
      o.rem = (gwv_pkg::VW+2)'(r - t);
      o.q   = {s.q[gwv_pkg::VW-2:0], 1'b1};
    end else begin
      o.rem = (gwv_pkg::VW+2)'(r);
      o.q   = {s.q[gwv_pkg::VW-2:0], 1'b0};
    end
    return o;
  endfunction

  for (genvar k = 0; k < gwv_pkg::SQ_STAGES; k++) begin : g_st
    if (k == 0) begin : g_first
      always_comb begin
        st_in[k].rem = '0;
        st_in[k].q   = '0;
        st_in[k].rad = rad_in;
      end
    end else begin : g_rest
      assign st_in[k] = st[k-1];
    end

    always_comb begin
      st_next[k] = st_in[k];
      for (int j = 0; j < gwv_pkg::SQ_STEPS; j++) begin
        st_next[k] = sq_step(st_next[k]);
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign root_out = st[gwv_pkg::SQ_STAGES-1].q;

endmodule

`default_nettype wire

@@ design/gwv_check.sv @@
// ----------------------------------------------------------------------------
// gwv_check: port-level checks for the window validity pipeline
// Watches the stream handshakes and the result format over time.
// ----------------------------------------------------------------------------
`default_nettype none

module gwv_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // an empty or draining output never blocks requests
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("request refused with output free");

  // only the valid bit is ever set
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:1] == 7'd0))
    else $error("result pad bits set");

endmodule

bind geodesic_window_validity_check_top gwv_check u_gwv_check (.*);

`default_nettype wire
